// ===== src/abmf_pkg.sv =====
// ----------------------------------------------------------------------------
// abmf_pkg
// Shared widths, opcodes and flag limits for the 8-bit ALU with a Booth
// multiplier and status flags.
// ----------------------------------------------------------------------------
package abmf_pkg;

  localparam int OPND_W    = 8;   // operand port width
  localparam int CMD_W     = 4;   // command port width
  localparam int ACC_W     = 16;  // accumulator width
  localparam int ALU_W_DEF = 8;   // default datapath width

  localparam logic [CMD_W-1:0] CMD_ADD = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SUB = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MUL = 4'd3;
  localparam logic [CMD_W-1:0] CMD_AND = 4'd4;
  localparam logic [CMD_W-1:0] CMD_OR  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_NOT = 4'd6;
  localparam logic [CMD_W-1:0] CMD_XOR = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SHR = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SHL = 4'd9;

  localparam logic [ACC_W-1:0] CARRY_LIMIT = 16'h01FF;
  localparam logic [ACC_W-1:0] OVF_LIMIT   = 16'h00FF;

endpackage

// ===== src/alu8_booth_multiply_flags_unit.sv =====
// ----------------------------------------------------------------------------
// alu8_booth_multiply_flags_unit
// Accumulator ALU: add, sub, Booth multiply, logic ops and shifts, with flags.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_ready carry operand_a, operand_b, command.
//   Result channel:  out_valid/out_ready carry acc_value and the flags.
//   Each request yields exactly one result, in order.
//   A request accepted into the input register moves on into the result
//   register once that is free (one input register, one result register).
//   Throughput: one request per cycle, sustained, while results are taken.
//   The accumulator feeds back from the result stage into the compute
//   stage, where invalid commands keep it; every valid operation replaces it.
//   Stall: if out_ready is low the result holds; one more request may still
//   be taken into the input register, then in_ready drops until space frees.
//   Reset (rst, synchronous): both stages empty, accumulator cleared to 0,
//   flags as for a zero accumulator.
//   Invalid commands keep the accumulator, recompute flags, set bad_opcode.
//   ALU_W sets the ALU width; operand bits above it are ignored.
// ----------------------------------------------------------------------------
module alu8_booth_multiply_flags_unit #(
  parameter int ALU_W = abmf_pkg::ALU_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [abmf_pkg::OPND_W-1:0] operand_a,
  input  logic [abmf_pkg::OPND_W-1:0] operand_b,
  input  logic [abmf_pkg::CMD_W-1:0]  command,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [abmf_pkg::ACC_W-1:0]  acc_value,
  output logic                        zero_flag,
  output logic                        carry_flag,
  output logic                        overflow_flag,
  output logic                        sign_flag,
  output logic                        bad_opcode
);

  import abmf_pkg::*;

  localparam int DW = ALU_W;
  localparam int SW = (DW > 1) ? $clog2(DW) : 1;  // shift amount bits when < DW

  // ---- input register -------------------------------------------------------
  logic              s1_valid;
  logic [OPND_W-1:0] s1_a;
  logic [OPND_W-1:0] s1_b;
  logic [CMD_W-1:0]  s1_cmd;
  logic              s1_adv;    // stage 1 moves into the result register

  // ---- result register / accumulator ----------------------------------------
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;

  // ---- compute stage ---------------------------------------------------------
  logic [DW-1:0]     a_m;
  logic [DW-1:0]     b_m;
  logic [DW-1:0]     r;
  logic [2*DW-1:0]   prod;
  logic [ACC_W-1:0]  r_acc;
  logic              bad;
  logic              sign_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_a   <= operand_a;
      s1_b   <= operand_b;
      s1_cmd <= command;
    end
  end

  // bits above ALU_W drop out here (or zero-extend for wider datapaths)
  assign a_m = DW'(s1_a);
  assign b_m = DW'(s1_b);

  abmf_booth_mul #(
    .DW (DW)
  ) u_mul (
    .a (a_m),
    .b (b_m),
    .p (prod)
  );

  always_comb begin
    r   = '0;
    bad = 1'b0;
    case (s1_cmd)
      CMD_ADD: r = a_m + b_m;
      CMD_SUB: r = a_m - b_m;
      CMD_MUL: r = '0;              // product taken separately, wider
      CMD_AND: r = a_m & b_m;
      CMD_OR:  r = a_m | b_m;
      CMD_NOT: r = ~a_m;
      CMD_XOR: r = a_m ^ b_m;
      CMD_SHR: r = (b_m >= DW'(DW)) ? '0 : (a_m >> b_m[SW-1:0]);
      CMD_SHL: r = (b_m >= DW'(DW)) ? '0 : (a_m << b_m[SW-1:0]);
      default: bad = 1'b1;
    endcase
  end

  assign r_acc    = (s1_cmd == CMD_MUL) ? ACC_W'(prod) : ACC_W'(r);
  assign acc_next = bad ? acc : r_acc;

  // sign comes from the datapath's top bit, if the accumulator has it
  generate
    if (DW - 1 < ACC_W) begin : g_sign
      assign sign_next = acc_next[DW-1];
    end else begin : g_nosign
      assign sign_next = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      acc           <= '0;
      zero_flag     <= 1'b1;
      carry_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      sign_flag     <= 1'b0;
      bad_opcode    <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid     <= 1'b1;
        acc           <= acc_next;
        zero_flag     <= (acc_next == '0);
        carry_flag    <= (acc_next >= CARRY_LIMIT);
        overflow_flag <= (acc_next >= OVF_LIMIT);
        sign_flag     <= sign_next;
        bad_opcode    <= bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the accumulator only changes when a result loads, so it is the result
  assign acc_value = acc;

`ifndef SYNTHESIS
  // accumulator moves only with a loaded result
  assert property (@(posedge clk) disable iff (rst) !s1_adv |=> $stable(acc))
    else $error("accumulator changed without a result load");

  // a bad command keeps the accumulator and reports it
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && bad) |=> ($stable(acc) && bad_opcode && out_valid))
    else $error("bad command altered accumulator or was not flagged");

  // zero and overflow flags track the accumulator they were computed from
  assert property (@(posedge clk) disable iff (rst)
    (zero_flag == (acc == '0)) && (overflow_flag == (acc >= OVF_LIMIT)))
    else $error("flags out of step with accumulator");
`endif

endmodule

// ===== src/abmf_booth_mul.sv =====
// ----------------------------------------------------------------------------
// abmf_booth_mul
// Signed radix-4 Booth multiplier, combinational, full 2*DW-bit product.
// ----------------------------------------------------------------------------
module abmf_booth_mul #(
  parameter int DW = 8
) (
  input  logic [DW-1:0]   a,
  input  logic [DW-1:0]   b,
  output logic [2*DW-1:0] p
);

  localparam int NB  = DW + (DW % 2);  // multiplier width rounded up to even
  localparam int NPP = NB / 2;         // number of Booth digits
  localparam int PW  = 2 * DW;

  logic [NB:0]   bx;                   // sign-extended multiplier, zero appended
  logic [PW-1:0] ax;
  logic [PW-1:0] ax2;
  logic [PW-1:0] pp [NPP];

  assign bx  = {NB'($signed(b)), 1'b0};
  assign ax  = PW'($signed(a));
  assign ax2 = {ax[PW-2:0], 1'b0};

  // one partial product per digit, all independent
  always_comb begin
    for (int i = 0; i < NPP; i++) begin
      case (bx[2*i +: 3])
        3'b001, 3'b010: pp[i] = ax << (2 * i);
        3'b011:         pp[i] = ax2 << (2 * i);
        3'b100:         pp[i] = (~ax2 + 1'b1) << (2 * i);
        3'b101, 3'b110: pp[i] = (~ax + 1'b1) << (2 * i);
        default:        pp[i] = '0;
      endcase
    end
  end

  always_comb begin
    p = '0;
    for (int i = 0; i < NPP; i++) begin
      p = p + pp[i];
    end
  end

endmodule
